### hdl/tli_pkg.sv
// package for the table linear interpolator: types, codes and constants
// no dependencies
`default_nettype none
package tli_pkg;
    localparam int unsigned DataWidth = 32;
    localparam int unsigned CfgIndexWidth = 2;

    typedef enum logic [1:0] {
        CFG_EQUAL_SPACING = 2'd0,
        CFG_START         = 2'd1,
        CFG_STEP          = 2'd2,
        CFG_ENTRIES       = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        CLAMP_NONE  = 2'd0,
        CLAMP_FIRST = 2'd1,
        CLAMP_LAST  = 2'd2
    } clamp_t;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EQ_DIV,
        ST_EQ_FRAC,
        ST_RD_FIRST,
        ST_TB_FIRST,
        ST_TB_SCAN,
        ST_TB_WAIT,
        ST_TB_FRAC,
        ST_RD_LO,
        ST_RD_HI,
        ST_MUL,
        ST_SAT,
        ST_OUT
    } state_t;

    // divider control and status
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [31:0] rem;
    } div_rsp_t;
endpackage
`default_nettype wire

### hdl/tli_if.sv
// valid/ready stream interfaces for item, result and configuration transfers
// depends on nothing
`default_nettype none
interface tli_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [5:0]  entry_index;
    logic [31:0] entry_wavelength;
    logic signed [31:0] entry_value;
    logic [31:0] query_wavelength;
    modport source (output valid, op, entry_index, entry_wavelength, entry_value,
                    query_wavelength, input ready);
    modport sink (input valid, op, entry_index, entry_wavelength, entry_value,
                  query_wavelength, output ready);
endinterface

interface tli_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] interpolated_value;
    logic [1:0]  clamp_status;
    modport source (output valid, interpolated_value, clamp_status, input ready);
    modport sink (input valid, interpolated_value, clamp_status, output ready);
endinterface

interface tli_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/tli_divider.sv
// restoring radix-2 divider, 64-bit numerator by 32-bit divisor, one bit a cycle
// depends on tli_pkg
`default_nettype none
module tli_divider
    import tli_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic [6:0]  count_reg, count_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [32:0] trial;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        trial      = {rem_reg[31:0], quo_reg[63]};
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = 7'd0;
            quo_next   = req.num;
            rem_next   = '0;
            den_next   = req.den;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[62:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = trial - {1'b0, den_reg};
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            count_next = count_reg + 7'd1;
            if (count_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg[31:0];
endmodule
`default_nettype wire

### hdl/tli_table_mem.sv
// sample table: wavelength and value memories, one write and one registered read port
// depends on nothing
`default_nettype none
module tli_table_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [31:0]   wr_wavelength,
    input  wire logic [31:0]   wr_value,
    input  wire logic [AW-1:0] rd_addr,
    output logic [31:0]        rd_wavelength,
    output logic [31:0]        rd_value
);
    logic [31:0] wl_mem [DEPTH];
    logic [31:0] val_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wl_mem[wr_addr]  <= wr_wavelength;
            val_mem[wr_addr] <= wr_value;
        end
        rd_wavelength <= wl_mem[rd_addr];
        rd_value      <= val_mem[rd_addr];
    end
endmodule
`default_nettype wire

### hdl/table_linear_interpolator_unit.sv
// top level of the table linear interpolator: control sequencer, config registers
// depends on tli_pkg, tli_if, tli_divider, tli_table_mem
//
// channel   dir  fields                                                  transfer when
// in_ch     in   op entry_index entry_wavelength entry_value query_wl    valid && ready
// out_ch    out  interpolated_value clamp_status                         valid && ready
// cfg_ch    in   index data                                              valid && ready
//
// a load is taken while idle. one item is worked at a time: a query holds the input
// off until its result is transferred. the divider is bit-serial. equal spacing divides
// the offset by the step, then the remainder for the fraction, unless clamped; table
// mode scans from the first sample and divides once in the bin found, unless the bin is
// flat or the query lies outside the samples. receiver stalls lengthen the output
// wait, after which the block returns to idle. no clearing pass.
`default_nettype none
module table_linear_interpolator_unit
    import tli_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH   = 64,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tli_in_if.sink    in_ch,
    tli_out_if.source out_ch,
    tli_cfg_if.sink   cfg_ch
);
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    // configuration registers
    logic        eq_reg;
    logic [31:0] start_reg;
    logic [31:0] step_reg;
    logic [6:0]  entries_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eq_reg      <= 1'b0;
            start_reg   <= '0;
            step_reg    <= 32'd65536;
            entries_reg <= 7'd2;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_index_t'(cfg_ch.index))
                CFG_EQUAL_SPACING: eq_reg      <= cfg_ch.data[0];
                CFG_START:         start_reg   <= cfg_ch.data;
                CFG_STEP:          step_reg    <= cfg_ch.data;
                CFG_ENTRIES:       entries_reg <= cfg_ch.data[6:0];
                default:           eq_reg      <= eq_reg;
            endcase
        end
    end
    assign cfg_ch.ready = 1'b1;

    // entry count clamped to [2, TABLE_DEPTH]
    logic [CW-1:0] n_use;
    always_comb
    begin
        if ({25'd0, entries_reg} < 32'd2)
            n_use = CW'(2);
        else if ({25'd0, entries_reg} > TABLE_DEPTH)
            n_use = CW'(TABLE_DEPTH);
        else
            n_use = CW'(entries_reg);
    end
    logic [AW-1:0] last_idx;
    assign last_idx = AW'(n_use - CW'(1));
    logic [31:0] step_eff;
    assign step_eff = (step_reg == '0) ? 32'd1 : step_reg;

    // sequencer state
    state_t state_reg, state_next;
    logic [31:0]   q_reg, q_next;
    logic [AW-1:0] addr_reg, addr_next;        // memory read address
    logic [CW-1:0] idx_reg, idx_next;          // scan index
    logic [31:0]   wl_lo_reg, wl_lo_next;      // previous wavelength in scan
    logic [31:0]   v0_reg, v0_next;
    logic [31:0]   v1_reg, v1_next;
    logic [FRACTION_BITS:0] t_reg, t_next;
    logic signed [65:0] prod_reg;
    logic [1:0]    stat_reg, stat_next;
    logic [AW-1:0] hi_addr_reg, hi_addr_next;
    logic          blend_reg, blend_next;      // interpolate rather than pick v1
    div_req_t      dreq;
    div_rsp_t      drsp;

    // result pipeline after ST_SAT
    logic [1:0]  fin_reg;
    logic        interp_reg;
    logic [31:0] out_val_reg;
    logic [1:0]  wait_reg;
    logic        out_ok;

    logic [31:0] rd_wl, rd_val;
    logic        wr_en;
    logic        load_ok;

    assign load_ok = ({26'd0, in_ch.entry_index} < TABLE_DEPTH);
    assign wr_en   = in_ch.valid && in_ch.ready && (in_ch.op == OP_LOAD) && load_ok;

    tli_table_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
        .clk           (clk),
        .wr_en         (wr_en),
        .wr_addr       (AW'(in_ch.entry_index)),
        .wr_wavelength (in_ch.entry_wavelength),
        .wr_value      (in_ch.entry_value),
        .rd_addr       (addr_reg),
        .rd_wavelength (rd_wl),
        .rd_value      (rd_val)
    );

    tli_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    logic [31:0] sc_num, sc_den;
    assign sc_num = (q_reg > wl_lo_reg) ? q_reg - wl_lo_reg : 32'd0;
    assign sc_den = (rd_wl > wl_lo_reg) ? rd_wl - wl_lo_reg : 32'd0;

    // arithmetic shift floors for either sign of the product
    logic signed [32:0] diff;
    logic signed [65:0] part;
    logic signed [65:0] sum;
    assign diff = $signed({v1_reg[31], v1_reg}) - $signed({v0_reg[31], v0_reg});
    assign part = prod_reg >>> FRACTION_BITS;
    assign sum  = part + 66'($signed(v0_reg));

    always_comb
    begin
        state_next   = state_reg;
        q_next       = q_reg;
        addr_next    = addr_reg;
        idx_next     = idx_reg;
        wl_lo_next   = wl_lo_reg;
        v0_next      = v0_reg;
        v1_next      = v1_reg;
        t_next       = t_reg;
        stat_next    = stat_reg;
        hi_addr_next = hi_addr_reg;
        blend_next   = blend_reg;
        dreq.start   = 1'b0;
        dreq.num     = '0;
        dreq.den     = step_eff;
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                q_next      = in_ch.query_wavelength;
                if (in_ch.valid && in_ch.op == OP_QUERY)
                begin
                    stat_next  = CLAMP_NONE;
                    addr_next  = '0;
                    blend_next = 1'b0;
                    if (eq_reg)
                    begin
                        if (in_ch.query_wavelength < start_reg)
                        begin
                            stat_next  = CLAMP_FIRST;
                            state_next = ST_RD_HI;
                            hi_addr_next = '0;
                        end
                        else
                        begin
                            dreq.start = 1'b1;
                            dreq.num   = {32'd0, in_ch.query_wavelength - start_reg};
                            state_next = ST_EQ_DIV;
                        end
                    end
                    else
                        state_next = ST_RD_FIRST;
                end
            end
            ST_EQ_DIV:
            begin
                if (drsp.done)
                begin
                    if (drsp.quo >= 64'(last_idx))
                    begin
                        stat_next    = CLAMP_LAST;
                        hi_addr_next = last_idx;
                        state_next   = ST_RD_HI;
                    end
                    else
                    begin
                        addr_next    = AW'(drsp.quo);
                        hi_addr_next = AW'(drsp.quo) + AW'(1);
                        blend_next   = 1'b1;
                        dreq.start   = 1'b1;
                        dreq.num     = {32'd0, drsp.rem} << FRACTION_BITS;
                        state_next   = ST_EQ_FRAC;
                    end
                end
            end
            ST_EQ_FRAC,
            ST_TB_FRAC:
            begin
                if (drsp.done)
                begin
                    t_next     = drsp.quo[FRACTION_BITS:0];
                    state_next = ST_RD_LO;
                end
            end
            ST_RD_FIRST:
                state_next = ST_TB_FIRST;   // address 0 read in flight
            ST_TB_FIRST:
            begin
                if (q_reg <= rd_wl)
                begin
                    stat_next    = CLAMP_FIRST;
                    hi_addr_next = '0;
                    state_next   = ST_RD_HI;
                end
                else
                begin
                    wl_lo_next = rd_wl;
                    idx_next   = CW'(1);
                    addr_next  = AW'(1);
                    state_next = ST_TB_WAIT;
                end
            end
            ST_TB_WAIT:
                state_next = ST_TB_SCAN;
            ST_TB_SCAN:
            begin
                if (q_reg <= rd_wl)
                begin
                    hi_addr_next = AW'(idx_reg);
                    if (sc_den == '0 || sc_num >= sc_den)
                        state_next = ST_RD_HI;
                    else
                    begin
                        blend_next = 1'b1;
                        addr_next  = AW'(idx_reg - CW'(1));
                        dreq.start = 1'b1;
                        dreq.num   = {32'd0, sc_num} << FRACTION_BITS;
                        dreq.den   = sc_den;
                        state_next = ST_TB_FRAC;
                    end
                end
                else if (idx_reg + CW'(1) >= n_use)
                begin
                    stat_next    = CLAMP_LAST;
                    hi_addr_next = last_idx;
                    state_next   = ST_RD_HI;
                end
                else
                begin
                    wl_lo_next = rd_wl;
                    idx_next   = idx_reg + CW'(1);
                    addr_next  = AW'(idx_reg + CW'(1));
                    state_next = ST_TB_WAIT;
                end
            end
            ST_RD_LO:
            begin
                // addr holds low entry; issue high next
                addr_next  = hi_addr_reg;
                state_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                if (blend_reg)
                begin
                    v0_next    = rd_val;
                    blend_next = 1'b0;
                    state_next = ST_MUL;
                end
                else
                begin
                    addr_next  = hi_addr_reg;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
                state_next = ST_SAT;        // high entry read in flight
            ST_SAT:
            begin
                v1_next    = rd_val;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // offer only once product and saturation have settled
                if (out_ok)
                begin
                    out_ch.valid = 1'b1;
                    if (out_ch.ready)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // result formation runs in a small side pipeline from ST_SAT
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fin_reg    <= '0;
            interp_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
                interp_reg <= 1'b0;
            else if (state_reg == ST_RD_HI && blend_reg)
                interp_reg <= 1'b1;
            fin_reg <= {fin_reg[0], (state_reg == ST_SAT)};
        end
    end

    // payload: product registered in the cycle after v1, saturated value in the cycle after the product
    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        addr_reg    <= addr_next;
        idx_reg     <= idx_next;
        wl_lo_reg   <= wl_lo_next;
        v0_reg      <= v0_next;
        v1_reg      <= v1_next;
        t_reg       <= t_next;
        stat_reg    <= stat_next;
        hi_addr_reg <= hi_addr_next;
        blend_reg   <= blend_next;
        prod_reg    <= diff * $signed({1'b0, t_reg});
        wait_reg    <= fin_reg;
        if (!interp_reg)
            out_val_reg <= v1_reg;
        else if (sum > 66'sd2147483647)
            out_val_reg <= 32'h7fff_ffff;
        else if (sum < -66'sd2147483648)
            out_val_reg <= 32'h8000_0000;
        else
            out_val_reg <= sum[31:0];
    end

    // hold output until multiply and saturation pipeline has settled
    assign out_ok = (wait_reg == 2'b00) && (fin_reg == 2'b00);
    assign out_ch.interpolated_value = out_val_reg;
    assign out_ch.clamp_status       = stat_reg;
endmodule
`default_nettype wire

### tb/sv/table_linear_interpolator_unit_tb.sv
// testbench for table_linear_interpolator_unit: directed and random loads and queries,
// predicted results checked per transfer. depends on tli_pkg, tli_if and the rtl
`default_nettype none
module table_linear_interpolator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tli_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tli_in_if  in_ch ();
    tli_out_if out_ch ();
    tli_cfg_if cfg_ch ();

    table_linear_interpolator_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    always #1 clk = ~clk;

    typedef struct {
        logic signed [31:0] value;
        clamp_t             status;
    } interp_result_t;

    // predictor state
    logic        eq_mode;
    logic [31:0] start_wl;
    logic [31:0] step_wl;
    logic [6:0]  n_entries;
    logic [31:0] wl_table [64];
    logic [31:0] val_table [64];

    interp_result_t expected_q[$];
    int  mismatches = 0;
    bit  calm = 1'b0;       // no idling in the last part
    bit  sink_hold = 1'b0;  // long receiver stall request

    // v0 + floor((v1-v0)*t / 2^16) with saturation
    function automatic logic [31:0] blend_values(logic [31:0] lo, logic [31:0] hi,
                                                 longint t);
        longint v0, v1, prod, part, res;
        v0 = longint'($signed(lo));
        v1 = longint'($signed(hi));
        prod = (v1 - v0) * t;
        part = prod >>> 16;   // arithmetic shift floors
        res = v0 + part;
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        return res[31:0];
    endfunction

    function automatic interp_result_t interpolate(logic [31:0] q);
        interp_result_t r;
        int unsigned n;
        longint unsigned stp, off, bin, rem, num, den, t;
        bit found;
        n = n_entries < 2 ? 2 : (n_entries > 64 ? 64 : n_entries);
        r.status = CLAMP_NONE;
        if (eq_mode) begin
            stp = step_wl == 0 ? 1 : step_wl;
            if (q < start_wl) begin
                r.value = val_table[0];
                r.status = CLAMP_FIRST;
            end
            else begin
                off = q - start_wl;
                bin = off / stp;
                rem = off % stp;
                if (bin >= n - 1) begin
                    r.value = val_table[n-1];
                    r.status = CLAMP_LAST;
                end
                else begin
                    t = (rem << 16) / stp;
                    r.value = blend_values(val_table[bin], val_table[bin+1], t);
                end
            end
        end
        else if (q <= wl_table[0]) begin
            r.value = val_table[0];
            r.status = CLAMP_FIRST;
        end
        else begin
            found = 0;
            r.value = val_table[n-1];
            for (int i = 1; i < n && !found; i++) begin
                if (q <= wl_table[i]) begin
                    num = q > wl_table[i-1] ? q - wl_table[i-1] : 0;
                    den = wl_table[i] > wl_table[i-1] ? wl_table[i] - wl_table[i-1] : 0;
                    found = 1;
                    if (den == 0 || num >= den)
                        r.value = val_table[i];
                    else
                        r.value = blend_values(val_table[i-1], val_table[i],
                                               (num << 16) / den);
                end
            end
            if (!found) r.status = CLAMP_LAST;
        end
        return r;
    endfunction

    function automatic int unsigned used_count();
        return n_entries < 2 ? 2 : (n_entries > 64 ? 64 : n_entries);
    endfunction

    // ------------------------------------------------------------------
    // configuration writes, only while the block is idle
    // ------------------------------------------------------------------
    task automatic write_reg(cfg_index_t idx, logic [31:0] data);
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_EQUAL_SPACING: eq_mode = data[0];
            CFG_START:         start_wl = data;
            CFG_STEP:          step_wl = data;
            CFG_ENTRIES:       n_entries = data[6:0];
            default: ;
        endcase
    endtask

    // wait until all results are back, then let the block settle
    task automatic drain();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // one item transfer; the predictor runs at acceptance
    // valid stays up after a transfer until the next idle, drain or register write
    // ------------------------------------------------------------------
    task automatic send_item(logic op, logic [5:0] idx, logic [31:0] wl,
                             logic [31:0] val, logic [31:0] q);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.op               <= op;
        in_ch.entry_index      <= idx;
        in_ch.entry_wavelength <= wl;
        in_ch.entry_value      <= val;
        in_ch.query_wavelength <= q;
        do @(posedge clk); while (!in_ch.ready);
        if (op == OP_LOAD) begin
            wl_table[idx] = wl;
            val_table[idx] = val;
        end
        else
            expected_q.insert(expected_q.size(), interpolate(q));
    endtask

    task automatic load_entry(int idx, logic [31:0] wl, logic [31:0] val);
        send_item(OP_LOAD, idx[5:0], wl, val, $urandom);
    endtask

    task automatic query(logic [31:0] q);
        send_item(OP_QUERY, 6'($urandom), $urandom, $urandom, q);
    endtask

    // ascending table over used slots with random spacing
    task automatic load_ascending_table(int unsigned n, logic [31:0] base,
                                        int unsigned max_gap);
        logic [31:0] wl;
        wl = base;
        for (int i = 0; i < n; i++) begin
            load_entry(i, wl, $urandom);
            wl = wl + $urandom_range(1, max_gap);
        end
    endtask

    // query near the used table, including exact sample points
    function automatic logic [31:0] table_query();
        int unsigned n, k;
        n = used_count();
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return wl_table[k];
            2: return wl_table[k] + 1;
            3: return wl_table[k] - 1;
            default: return wl_table[0] + $urandom_range(0, wl_table[n-1] - wl_table[0] + 4);
        endcase
    endfunction

    function automatic logic [31:0] equal_query();
        int unsigned n;
        n = used_count();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return start_wl + step_wl * $urandom_range(0, n);
            2: return start_wl - 1;
            default: return start_wl + $urandom_range(0, step_wl * n + 3);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checker and receiver idling
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result value %h status %0d", $time,
                         out_ch.interpolated_value, out_ch.clamp_status);
                mismatches++;
            end
            else begin
                interp_result_t e;
                e = expected_q.pop_front();
                if (out_ch.interpolated_value !== e.value)
                    begin
                        $display("%0t: value expected %h actual %h", $time, e.value,
                                 out_ch.interpolated_value);
                        mismatches++;
                    end
                if (out_ch.clamp_status !== e.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time, e.status,
                                 out_ch.clamp_status);
                        mismatches++;
                    end
            end
        end
    end

    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (sink_hold) out_ch.ready <= 1'b0;
            else if (gap > 0) begin
                gap--;
                out_ch.ready <= 1'b0;
            end
            else begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 9);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_table_directed();
        write_reg(CFG_EQUAL_SPACING, 0);
        write_reg(CFG_ENTRIES, 4);
        load_entry(0, 32'h0001_0000, 32'h8000_0000);
        load_entry(1, 32'h0002_0000, 32'h7fff_ffff);
        load_entry(2, 32'h0002_0000, 32'h0000_0000);  // zero width bin
        load_entry(3, 32'hffff_ffff, 32'hffff_0000);
        query(0);               // below first
        query(32'h0001_0000);   // at first
        query(32'h0001_8000);   // full scale swing
        query(32'h0002_0000);
        query(32'h0003_0000);
        query(32'hffff_ffff);   // at last
        load_entry(3, 32'hfff0_0000, 32'h0000_1234);
        query(32'hffff_ffff);   // above last
        load_entry(2, 32'h0001_8000, 32'h0000_5000);  // descending bin
        query(32'h0001_c000);
        // out of range index not possible with 6 bits; slot 63 at the top
        load_entry(63, 32'h1234_5678, 32'h0000_0001);
        drain();
    endtask

    task automatic test_equal_directed();
        write_reg(CFG_EQUAL_SPACING, 1);
        write_reg(CFG_START, 32'h0010_0000);
        write_reg(CFG_STEP, 32'h0001_0000);
        write_reg(CFG_ENTRIES, 3);
        query(32'h000f_ffff);   // below start
        query(32'h0010_0000);
        query(32'h0010_4000);
        query(32'h0012_0000);   // last bin clamp
        query(32'hffff_ffff);
        write_reg(CFG_STEP, 0); // zero step acts as one
        write_reg(CFG_START, 0);
        query(32'h0000_0000);
        query(32'h0000_0001);
        query(32'h0000_0002);
        write_reg(CFG_STEP, 32'hffff_ffff);
        write_reg(CFG_ENTRIES, 127); // above depth acts as full table
        load_ascending_table(64, 0, 1000);
        query(32'hffff_fffe);
        query(32'hffff_ffff);
        write_reg(CFG_ENTRIES, 0);   // below two acts as two
        query(32'h8000_0000);
        drain();
    endtask

    task automatic test_random_table(int items);
        write_reg(CFG_EQUAL_SPACING, 0);
        write_reg(CFG_ENTRIES, $urandom_range(2, 12));
        load_ascending_table(used_count(), $urandom_range(0, 32'h00ff_ffff),
                             $urandom_range(1, 32'h0004_0000));
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(0, 9) == 0)
                load_entry($urandom_range(0, used_count() - 1), $urandom, $urandom);
            else
                query(table_query());
        end
        drain();
    endtask

    task automatic test_random_equal(int items);
        write_reg(CFG_EQUAL_SPACING, 1);
        write_reg(CFG_START, $urandom);
        write_reg(CFG_STEP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h3_0000));
        write_reg(CFG_ENTRIES, $urandom_range(0, 3) == 0 ? 64 : $urandom_range(2, 10));
        for (int i = 0; i < used_count(); i++)
            load_entry(i, $urandom, $urandom);
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(0, 9) == 0)
                load_entry($urandom_range(0, used_count() - 1), $urandom, $urandom);
            else
                query(equal_query());
        end
        drain();
    endtask

    // receiver stalls for a long stretch while items keep coming
    task automatic test_backpressure();
        fork
            begin
                sink_hold = 1'b1;
                repeat (400) @(posedge clk);
                sink_hold = 1'b0;
            end
            for (int i = 0; i < 20; i++) query(equal_query());
        join
        drain();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.op = OP_LOAD;
        in_ch.entry_index = '0;
        in_ch.entry_wavelength = '0;
        in_ch.entry_value = '0;
        in_ch.query_wavelength = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_EQUAL_SPACING;
        cfg_ch.data = '0;
        eq_mode = 1'b0;
        start_wl = '0;
        step_wl = 32'd65536;
        n_entries = 7'd2;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_directed();
        test_equal_directed();
        for (int r = 0; r < 8; r++) begin
            test_random_table(80);
            test_random_equal(70);
        end
        test_backpressure();
        calm = 1'b1;
        test_random_table(60);
        test_random_equal(60);

        if (mismatches == 0 && expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
